FILE: rtl/spme_pkg.sv
// shared types and constants for the shortest path matrix engine
// used by shortest_path_matrix_engine and its checker
`default_nettype none
package spme_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned NODE_W     = 4;
  localparam int unsigned DIST_IN_W  = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned TOTAL_W    = 20;
  localparam int unsigned NCOUNT_W   = 5;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_DIST  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EXISTS    = 3'd3,
    ST_NO_PATH   = 3'd4
  } status_t;

  // register index of node_count on the configuration port
  localparam logic REG_NODE_COUNT = 1'b0;

endpackage
`default_nettype wire

FILE: rtl/spme_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module spme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/shortest_path_matrix_engine.sv
// shortest path engine over an undirected weighted adjacency matrix
// depends on spme_pkg and spme_ram
//
//  channel   signals                                              transaction at
//  command   start busy opcode first_node second_node edge_distance start && !busy
//  result    strobe status total_distance path_node last          every cycle strobe is high
//  config    psel penable pwrite paddr pwdata prdata pready       psel && penable && pready
//
// clear sweeps the edge ram one entry a cycle. a query's run time grows with the node
// count and the path length, set by the one-read-a-cycle node ram in scan and relax.
// after reset the same sweep clears the edge ram, busy is high for its length.
// results are shown for one cycle each, the receiver cannot stall them.
`default_nettype none
module shortest_path_matrix_engine #(
  parameter int unsigned MAX_NODE_COUNT = 16,
  parameter int unsigned EDGE_BITS      = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [spme_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [spme_pkg::NODE_W-1:0]   first_node,
  input  wire logic [spme_pkg::NODE_W-1:0]   second_node,
  input  wire logic [spme_pkg::DIST_IN_W-1:0] edge_distance,
  output logic                               strobe,
  output logic [spme_pkg::STATUS_W-1:0]      status,
  output logic [spme_pkg::TOTAL_W-1:0]       total_distance,
  output logic [spme_pkg::NODE_W-1:0]        path_node,
  output logic                               last,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spme_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [spme_pkg::PDATA_W-1:0]  pwdata,
  output logic [spme_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int unsigned NW    = $clog2(MAX_NODE_COUNT);
  localparam int unsigned CW    = $clog2(MAX_NODE_COUNT + 1);
  localparam int unsigned DW    = EDGE_BITS + NW;
  localparam int unsigned EAW   = 2 * NW;
  localparam int unsigned EDEPTH = 1 << EAW;
  localparam int unsigned NDEPTH = 1 << NW;
  localparam logic [63:0] EDGE_MAX  = (64'd1 << EDGE_BITS) - 64'd1;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << spme_pkg::TOTAL_W) - 64'd1;

  typedef struct packed {
    logic          reached;
    logic          visited;
    logic [NW:0]   pred;     // top bit set means no predecessor
    logic [DW-1:0] best;
  } node_rec_t;

  localparam int unsigned NRW = $bits(node_rec_t);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_ADD_CHK, S_ADD_WR2, S_INIT, S_SCAN, S_MARK, S_RELAX,
    S_FIN_RD, S_FIN, S_WALK_RD, S_WALK, S_EMIT
  } state_t;

  state_t state;

  logic [spme_pkg::NCOUNT_W-1:0] node_count;
  logic [CW-1:0]  n_act;
  logic [CW-1:0]  idx;
  logic           rv;
  logic [NW-1:0]  rj;
  logic           found;
  logic [NW-1:0]  cur;
  logic [DW-1:0]  cur_best;
  logic [NW:0]    cur_pred;
  logic [CW-1:0]  round;
  logic [NW-1:0]  src, dst, na, nb, wi;
  logic [EDGE_BITS-1:0] dval;
  logic [EAW-1:0] clr_cnt;
  logic           clr_report;
  logic [CW-1:0]  len;
  logic [DW-1:0]  tot;

  logic            node_we;
  logic [NW-1:0]   node_waddr, node_raddr;
  node_rec_t       node_wdata, node_rdata;
  logic [NRW-1:0]  node_rdata_raw;
  logic            edge_we;
  logic [EAW-1:0]  edge_waddr, edge_raddr;
  logic [EDGE_BITS-1:0] edge_wdata, edge_rdata;
  logic            stk_we;
  logic [NW-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic [DW-1:0]   cand;
  logic            relax_hit;
  logic            accept;
  logic            a_bad, b_bad;
  logic [EDGE_BITS-1:0] d_sat;
  logic [spme_pkg::TOTAL_W-1:0] tot_sat;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == spme_pkg::REG_NODE_COUNT) ?
                  spme_pkg::PDATA_W'(node_count) : '0;

  assign n_act = (32'(node_count) > MAX_NODE_COUNT) ? CW'(MAX_NODE_COUNT) : CW'(node_count);
  assign a_bad = 32'(first_node) >= 32'(n_act);
  assign b_bad = 32'(second_node) >= 32'(n_act);
  assign d_sat = (64'(edge_distance) > EDGE_MAX) ? '1 : EDGE_BITS'(edge_distance);
  assign tot_sat = (64'(tot) > TOTAL_MAX) ? '1 : spme_pkg::TOTAL_W'(tot);

  assign node_rdata = node_rec_t'(node_rdata_raw);
  assign cand = cur_best + DW'(edge_rdata);
  assign relax_hit = rv && !node_rdata.visited && (edge_rdata != '0) &&
                     (!node_rdata.reached || (cand < node_rdata.best));

  spme_ram #(.WIDTH(EDGE_BITS), .DEPTH(EDEPTH)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  spme_ram #(.WIDTH(NRW), .DEPTH(NDEPTH)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata_raw)
  );

  spme_ram #(.WIDTH(NW), .DEPTH(NDEPTH)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // memory port steering
  always_comb begin
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = idx[NW-1:0];
    edge_we    = 1'b0;
    edge_waddr = '0;
    edge_wdata = '0;
    edge_raddr = {cur, idx[NW-1:0]};
    stk_we     = 1'b0;
    stk_waddr  = len[NW-1:0];
    stk_wdata  = wi;
    stk_raddr  = NW'(idx - CW'(1));
    case (state)
      S_IDLE: begin
        edge_raddr = {NW'(first_node), NW'(second_node)};
      end
      S_CLR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_cnt;
      end
      S_ADD_CHK: begin
        edge_we    = (edge_rdata == '0);
        edge_waddr = {na, nb};
        edge_wdata = dval;
      end
      S_ADD_WR2: begin
        edge_we    = 1'b1;
        edge_waddr = {nb, na};
        edge_wdata = dval;
      end
      S_INIT: begin
        node_we    = 1'b1;
        node_waddr = idx[NW-1:0];
        node_wdata.reached = (idx[NW-1:0] == src);
        node_wdata.visited = 1'b0;
        node_wdata.pred    = {1'b1, NW'(0)};
        node_wdata.best    = '0;
      end
      S_MARK: begin
        node_we    = 1'b1;
        node_waddr = cur;
        node_wdata = '{reached: 1'b1, visited: 1'b1, pred: cur_pred, best: cur_best};
      end
      S_RELAX: begin
        node_we    = relax_hit;
        node_waddr = rj;
        node_wdata = '{reached: 1'b1, visited: 1'b0, pred: {1'b0, cur}, best: cand};
      end
      S_FIN_RD: begin
        node_raddr = dst;
      end
      S_WALK_RD: begin
        node_raddr = wi;
        stk_we     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      strobe     <= 1'b0;
      node_count <= '0;
      rv         <= 1'b0;
      found      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (psel && penable && pwrite && (paddr[2] == spme_pkg::REG_NODE_COUNT)) begin
        node_count <= pwdata[spme_pkg::NCOUNT_W-1:0];
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            na   <= NW'(first_node);
            nb   <= NW'(second_node);
            src  <= NW'(first_node);
            dst  <= NW'(second_node);
            dval <= d_sat;
            status         <= spme_pkg::ST_OK;
            total_distance <= '0;
            path_node      <= '0;
            last           <= 1'b1;
            case (opcode)
              spme_pkg::OP_CLEAR: begin
                state      <= S_CLR;
                clr_cnt    <= '0;
                clr_report <= 1'b1;
              end
              spme_pkg::OP_ADD: begin
                if (edge_distance == '0) begin
                  strobe <= 1'b1;
                  status <= spme_pkg::ST_BAD_DIST;
                end else if (a_bad || b_bad) begin
                  strobe <= 1'b1;
                  status <= spme_pkg::ST_NOT_FOUND;
                end else if (first_node == second_node) begin
                  strobe <= 1'b1;
                  status <= spme_pkg::ST_EXISTS;
                end else begin
                  state <= S_ADD_CHK;
                end
              end
              spme_pkg::OP_QUERY: begin
                if (a_bad || b_bad) begin
                  strobe <= 1'b1;
                  status <= spme_pkg::ST_NOT_FOUND;
                end else begin
                  idx   <= '0;
                  state <= S_INIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + EAW'(1);
          if (clr_cnt == '1) begin
            strobe         <= clr_report;
            status         <= spme_pkg::ST_OK;
            total_distance <= '0;
            path_node      <= '0;
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_ADD_CHK: begin
          if (edge_rdata != '0) begin
            strobe <= 1'b1;
            status <= spme_pkg::ST_EXISTS;
            state  <= S_IDLE;
          end else begin
            state <= S_ADD_WR2;
          end
        end
        S_ADD_WR2: begin
          strobe <= 1'b1;
          status <= spme_pkg::ST_OK;
          state  <= S_IDLE;
        end
        S_INIT: begin
          idx <= idx + CW'(1);
          if (idx + CW'(1) == n_act) begin
            idx   <= '0;
            round <= '0;
            rv    <= 1'b0;
            found <= 1'b0;
            state <= (n_act > CW'(1)) ? S_SCAN : S_FIN_RD;
          end
        end
        S_SCAN: begin
          if (idx < n_act) begin
            idx <= idx + CW'(1);
            rv  <= 1'b1;
            rj  <= idx[NW-1:0];
          end else begin
            rv <= 1'b0;
          end
          // strict less-than keeps the lowest index on ties
          if (rv && !node_rdata.visited && node_rdata.reached &&
              (!found || (node_rdata.best < cur_best))) begin
            found    <= 1'b1;
            cur      <= rj;
            cur_best <= node_rdata.best;
            cur_pred <= node_rdata.pred;
          end
          if ((idx == n_act) && !rv) begin
            state <= found ? S_MARK : S_FIN_RD;
          end
        end
        S_MARK: begin
          idx   <= '0;
          rv    <= 1'b0;
          state <= S_RELAX;
        end
        S_RELAX: begin
          if (idx < n_act) begin
            idx <= idx + CW'(1);
            rv  <= 1'b1;
            rj  <= idx[NW-1:0];
          end else begin
            rv <= 1'b0;
          end
          if ((idx == n_act) && !rv) begin
            round <= round + CW'(1);
            idx   <= '0;
            found <= 1'b0;
            state <= ((32'(round) + 32'd2) < 32'(n_act)) ? S_SCAN : S_FIN_RD;
          end
        end
        S_FIN_RD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!node_rdata.reached) begin
            strobe <= 1'b1;
            status <= spme_pkg::ST_NO_PATH;
            state  <= S_IDLE;
          end else begin
            tot   <= node_rdata.best;
            len   <= '0;
            wi    <= dst;
            state <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          len   <= len + CW'(1);
          state <= S_WALK;
        end
        S_WALK: begin
          if (node_rdata.pred[NW] || (len == n_act)) begin
            idx   <= len;
            rv    <= 1'b0;
            state <= S_EMIT;
          end else begin
            wi    <= node_rdata.pred[NW-1:0];
            state <= S_WALK_RD;
          end
        end
        S_EMIT: begin
          // stack holds destination first, so read it back top down
          if (idx != '0) begin
            idx <= idx - CW'(1);
            rv  <= 1'b1;
            rj  <= NW'(idx - CW'(1));
          end else begin
            rv <= 1'b0;
          end
          if (rv) begin
            strobe         <= 1'b1;
            status         <= spme_pkg::ST_OK;
            total_distance <= tot_sat;
            path_node      <= spme_pkg::NODE_W'(stk_rdata);
            last           <= (rj == '0);
            if (rj == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spme_checker.sv
// port-level checks for shortest_path_matrix_engine, bound to the top level
// depends on spme_pkg
`default_nettype none
module spme_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              busy,
  input wire logic                              strobe,
  input wire logic [spme_pkg::STATUS_W-1:0]     status,
  input wire logic [spme_pkg::TOTAL_W-1:0]      total_distance,
  input wire logic [spme_pkg::NODE_W-1:0]       path_node,
  input wire logic                              last
);

  // reset starts the edge clearing sweep and shows no result
  a_reset_sweep: assert property (@(posedge clk) rst |=> busy && !strobe)
    else $error("no clearing sweep after reset");

  // a path transaction that is not finished keeps the block busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("result stream ended without last");

  // error results come alone
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != spme_pkg::ST_OK) |-> last)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != spme_pkg::ST_OK) |-> (total_distance == '0) && (path_node == '0))
    else $error("error result carries payload");

  // path results of one query share one total
  a_same_total: assert property (@(posedge clk) disable iff (rst)
    strobe && !last ##1 strobe |-> $stable(total_distance))
    else $error("total distance changed within a path");

endmodule

bind shortest_path_matrix_engine spme_checker u_spme_checker (
  .clk(clk), .rst(rst), .busy(busy), .strobe(strobe), .status(status),
  .total_distance(total_distance), .path_node(path_node), .last(last)
);
`default_nettype wire

FILE: tb/tb_shortest_path_matrix_engine.sv
// self-checking testbench for shortest_path_matrix_engine: clear, add edge and path queries
// checked against an in-bench graph model; depends on spme_pkg and the engine rtl
`default_nettype none
module tb_shortest_path_matrix_engine;

  localparam int unsigned NODES      = 16;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned DRAIN      = 300;

  typedef struct {
    spme_pkg::opcode_t op;
    logic [3:0]      a;
    logic [3:0]      b;
    logic [15:0]     weight;
  } command_t;

  typedef struct {
    spme_pkg::status_t st;
    logic [19:0]     total;
    logic [3:0]      node;
    logic            last;
  } path_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [spme_pkg::OPCODE_W-1:0] opcode = '0;
  logic [spme_pkg::NODE_W-1:0] first_node = '0;
  logic [spme_pkg::NODE_W-1:0] second_node = '0;
  logic [spme_pkg::DIST_IN_W-1:0] edge_distance = '0;
  logic strobe;
  logic [spme_pkg::STATUS_W-1:0] status;
  logic [spme_pkg::TOTAL_W-1:0] total_distance;
  logic [spme_pkg::NODE_W-1:0] path_node;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [spme_pkg::PADDR_W-1:0] paddr = '0;
  logic [spme_pkg::PDATA_W-1:0] pwdata = '0;
  logic [spme_pkg::PDATA_W-1:0] prdata;
  logic pready;

  shortest_path_matrix_engine uut (
    .clk, .rst, .start, .busy, .opcode, .first_node, .second_node, .edge_distance,
    .strobe, .status, .total_distance, .path_node, .last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // graph model
  logic [15:0] adjacency [NODES][NODES];
  logic [4:0] node_count_reg;
  command_t pending_cmds [$];
  path_result_t expected_paths [$];
  command_t cur_cmd;
  int errors = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int sender_idle_pct = 0;
  int unsigned cycles = 0;

  function automatic int active_nodes();
    return (node_count_reg > NODES) ? NODES : int'(node_count_reg);
  endfunction

  function automatic void push_result(spme_pkg::status_t st, logic [19:0] total,
                                      logic [3:0] node, logic lst);
    path_result_t r;
    r.st = st;
    r.total = total;
    r.node = node;
    r.last = lst;
    expected_paths.push_back(r);
  endfunction

  function automatic void predict_shortest_path(int src, int dst);
    int n;
    int cur;
    int len;
    int walk;
    bit found;
    int unsigned best [NODES];
    int unsigned cand;
    bit reached [NODES];
    bit done [NODES];
    int prev [NODES];
    int trail [NODES];
    n = active_nodes();
    if (src >= n || dst >= n) begin
      push_result(spme_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < NODES; i++) begin
      best[i] = 0;
      reached[i] = 0;
      done[i] = 0;
      prev[i] = -1;
    end
    reached[src] = 1;
    for (int round = 0; round + 1 < n; round++) begin
      found = 0;
      cur = 0;
      // strict less-than: lowest index wins ties
      for (int j = 0; j < n; j++) begin
        if (!done[j] && reached[j] && (!found || best[j] < best[cur])) begin
          found = 1;
          cur = j;
        end
      end
      if (!found) break;
      done[cur] = 1;
      for (int j = 0; j < n; j++) begin
        if (!done[j] && adjacency[cur][j] != 0) begin
          cand = best[cur] + adjacency[cur][j];
          if (!reached[j] || cand < best[j]) begin
            best[j] = cand;
            reached[j] = 1;
            prev[j] = cur;
          end
        end
      end
    end
    if (!reached[dst]) begin
      push_result(spme_pkg::ST_NO_PATH, '0, '0, 1'b1);
      return;
    end
    len = 0;
    walk = dst;
    while (len < n) begin
      trail[len] = walk;
      len++;
      if (prev[walk] < 0 || prev[walk] >= n) break;
      walk = prev[walk];
    end
    for (int j = 0; j < len; j++)
      push_result(spme_pkg::ST_OK, (best[dst] > 20'hFFFFF) ? 20'hFFFFF : best[dst][19:0],
                  trail[len-1-j][3:0], j + 1 == len);
  endfunction

  function automatic void predict_command(command_t c);
    int n;
    n = active_nodes();
    case (c.op)
      spme_pkg::OP_CLEAR: begin
        for (int i = 0; i < NODES; i++)
          for (int j = 0; j < NODES; j++) adjacency[i][j] = '0;
        push_result(spme_pkg::ST_OK, '0, '0, 1'b1);
      end
      spme_pkg::OP_ADD: begin
        if (c.weight == 0) push_result(spme_pkg::ST_BAD_DIST, '0, '0, 1'b1);
        else if (c.a >= n || c.b >= n) push_result(spme_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
        else if (c.a == c.b || adjacency[c.a][c.b] != 0)
          push_result(spme_pkg::ST_EXISTS, '0, '0, 1'b1);
        else begin
          adjacency[c.a][c.b] = c.weight;
          adjacency[c.b][c.a] = c.weight;
          push_result(spme_pkg::ST_OK, '0, '0, 1'b1);
        end
      end
      spme_pkg::OP_QUERY: begin
        queries_sent++;
        predict_shortest_path(c.a, c.b);
      end
      default: ;
    endcase
  endfunction

  // command driver
  always @(posedge clk) begin
    command_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_command(cur_cmd);
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = pending_cmds.pop_front();
          cur_cmd = nxt;
          opcode <= nxt.op;
          first_node <= nxt.a;
          second_node <= nxt.b;
          edge_distance <= nxt.weight;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    path_result_t e;
    if (!rst && strobe) begin
      results_seen++;
      if (expected_paths.size() == 0) begin
        $error("unexpected result transaction: status %0d node %0d", status, path_node);
        errors++;
      end else begin
        e = expected_paths.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, actual %0d", e.st, status);
          errors++;
        end
        if (total_distance !== e.total) begin
          $error("total_distance: expected %0d, actual %0d", e.total, total_distance);
          errors++;
        end
        if (path_node !== e.node) begin
          $error("path_node: expected %0d, actual %0d", e.node, path_node);
          errors++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || start || busy || expected_paths.size() != 0);
    // an unused opcode gives no result, allow for any leftover work
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_node_count(logic [4:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= spme_pkg::PADDR_W'(4 * spme_pkg::REG_NODE_COUNT);
    pwdata <= spme_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    node_count_reg = value;
  endtask

  task automatic queue_cmd(spme_pkg::opcode_t op, int a, int b, int weight);
    command_t c;
    c.op = op;
    c.a = a[3:0];
    c.b = b[3:0];
    c.weight = weight[15:0];
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random(int count);
    int n;
    int r;
    int d;
    for (int k = 0; k < count; k++) begin
      n = active_nodes();
      if (n == 0) n = 16;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: d = 0;
        1, 2: d = $urandom_range(1, 65535);
        default: d = $urandom_range(1, 40);
      endcase
      if (r < 4) queue_cmd(spme_pkg::OP_CLEAR, 0, 0, 0);
      else if (r < 55)
        queue_cmd(spme_pkg::OP_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1), d);
      else if (r < 88)
        queue_cmd(spme_pkg::OP_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                  $urandom);
      else if (r < 96)
        queue_cmd(spme_pkg::opcode_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom);
      else queue_cmd(spme_pkg::OP_NONE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    end
  endtask

  initial begin
    int idle_plan [4];
    logic [4:0] count_plan [4];
    idle_plan = '{0, 86, 0, 36};
    count_plan = '{5'd31, 5'd1, 5'd7, 5'd16};
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++) adjacency[i][j] = '0;
    node_count_reg = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // no nodes in use
    queue_cmd(spme_pkg::OP_QUERY, 0, 0, 0);
    queue_cmd(spme_pkg::OP_ADD, 0, 1, 5);
    queue_cmd(spme_pkg::OP_ADD, 0, 1, 0);
    wait_idle();
    write_node_count(5'd16);
    queue_cmd(spme_pkg::OP_ADD, 0, 15, 65535);
    queue_cmd(spme_pkg::OP_ADD, 15, 0, 3);
    queue_cmd(spme_pkg::OP_ADD, 3, 3, 1);
    queue_cmd(spme_pkg::OP_QUERY, 0, 15, 0);
    queue_cmd(spme_pkg::OP_QUERY, 15, 15, 0);
    queue_cmd(spme_pkg::OP_QUERY, 0, 7, 0);
    queue_cmd(spme_pkg::OP_NONE, 15, 15, 65535);
    queue_cmd(spme_pkg::OP_ADD, 0, 1, 1);
    queue_cmd(spme_pkg::OP_ADD, 1, 15, 1);
    queue_cmd(spme_pkg::OP_QUERY, 15, 0, 0);
    queue_cmd(spme_pkg::OP_CLEAR, 15, 15, 65535);
    queue_cmd(spme_pkg::OP_QUERY, 0, 15, 0);
    // equal-cost tie: direct edge stays since relaxation is strict
    queue_cmd(spme_pkg::OP_ADD, 2, 3, 4);
    queue_cmd(spme_pkg::OP_ADD, 2, 4, 2);
    queue_cmd(spme_pkg::OP_ADD, 4, 3, 2);
    queue_cmd(spme_pkg::OP_QUERY, 2, 3, 0);
    queue_cmd(spme_pkg::OP_ADD, 5, 6, 43690);
    queue_cmd(spme_pkg::OP_ADD, 6, 7, 21845);
    queue_cmd(spme_pkg::OP_QUERY, 7, 5, 0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      write_node_count(count_plan[p]);
      sender_idle_pct = idle_plan[p];
      queue_random(85);
      wait_idle();
    end
    write_node_count(5'd0);

    $display("covered %0d queries and %0d result transactions over node counts 0 to 31",
             queries_sent, results_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
